// ----- hdl/cvs_pkg.sv -----
package cvs_pkg;

   // Set limits and number format
   localparam int MAX_SAMPLES = 4096;
   localparam int FRAC_BITS   = 16;
   localparam int SAMPLE_W    = 16;
   localparam int SCORE_W     = 52;
   localparam int MIN_EXON    = 2;

   // Derived widths
   localparam int LOG_MAX = $clog2(MAX_SAMPLES);
   localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
   localparam int SUM_W   = SAMPLE_W + LOG_MAX;
   localparam int SQ_W    = 2 * SAMPLE_W + LOG_MAX;
   localparam int SUM2_W  = 2 * SUM_W;
   localparam int NUM_W   = SQ_W + CNT_W;
   localparam int DEN_W   = 2 * CNT_W;
   localparam int DVD_W   = NUM_W + FRAC_BITS;
   localparam int MEAN_W  = SUM_W + FRAC_BITS;
   localparam int STEP_W  = $clog2(DVD_W + 1);

   localparam logic [SCORE_W-1:0] SCORE_MAX = '1;

   // Controller to datapath
   typedef struct packed {
      logic accum;      // take one sample word
      logic clear;      // clear accumulators
      logic prep;       // square the sum, form n*(n-1), arm multiplier
      logic mul_step;   // one shift-add step of n*sumsq
      logic load_var;   // load variance dividend and divisor
      logic latch_var;  // keep the variance quotient
      logic load_mean;  // load intron mean dividend and divisor
      logic div_step;   // one restoring division step
      logic load_out;   // capture the result word
   } cvs_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic few;        // fewer than two exon samples
      logic no_intron;  // no intron samples
   } cvs_status_type;

endpackage

// ----- hdl/cvs_channels.sv -----
interface cvs_req_if import cvs_pkg::*;;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;
   logic                is_intron;
   logic                last;

   modport source (output valid, sample, is_intron, last, input ready);
   modport sink   (input valid, sample, is_intron, last, output ready);
endinterface

interface cvs_rsp_if import cvs_pkg::*;;
   logic               valid;
   logic               ready;
   logic [SCORE_W-1:0] score;
   logic               too_few;
   logic               overflow;

   modport source (output valid, score, too_few, overflow, input ready);
   modport sink   (input valid, score, too_few, overflow, output ready);
endinterface

// ----- hdl/cvs_dp.sv -----
module cvs_dp import cvs_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cvs_cmd_type         cmd,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic                is_intron,
   output cvs_status_type      status,
   output logic [SCORE_W-1:0]  score,
   output logic                too_few,
   output logic                overflow
);

   // Accumulators
   logic [SUM_W-1:0] exon_sum_ff, exon_sum_in;
   logic [SQ_W-1:0]  exon_sq_ff, exon_sq_in;
   logic [CNT_W-1:0] exon_cnt_ff, exon_cnt_in;
   logic [SUM_W-1:0] intron_sum_ff, intron_sum_in;
   logic [CNT_W-1:0] intron_cnt_ff, intron_cnt_in;
   logic             dropped_ff, dropped_in;

   // Working registers
   logic [SUM2_W-1:0]  sum2_ff, sum2_in;
   logic [DEN_W-1:0]   nn_ff, nn_in;
   logic [NUM_W-1:0]   prod_ff, prod_in;
   logic [NUM_W-1:0]   mcand_ff, mcand_in;
   logic [CNT_W-1:0]   mplier_ff, mplier_in;
   logic [DVD_W-1:0]   dq_ff, dq_in;
   logic [DEN_W-1:0]   rem_ff, rem_in;
   logic [DEN_W-1:0]   div_ff, div_in;
   logic [DVD_W-1:0]   varq_ff, varq_in;

   // Result word
   logic [SCORE_W-1:0] score_ff, score_in;
   logic               too_few_ff, too_few_in;
   logic               overflow_ff, overflow_in;

   logic [SAMPLE_W*2-1:0] sample_sq;
   logic                  exon_full;
   logic                  intron_full;
   logic [DEN_W:0]        trial;
   logic                  trial_ge;
   logic [DVD_W-1:0]      mean_sel;
   logic [DVD_W:0]        total;

   assign status.few       = exon_cnt_ff < CNT_W'(MIN_EXON);
   assign status.no_intron = intron_cnt_ff == '0;

   assign sample_sq   = (SAMPLE_W*2)'(sample) * (SAMPLE_W*2)'(sample);
   assign exon_full   = exon_cnt_ff == CNT_W'(MAX_SAMPLES);
   assign intron_full = intron_cnt_ff == CNT_W'(MAX_SAMPLES);

   // Accumulate one sample, drop it when its class is full
   always_comb begin
      exon_sum_in   = exon_sum_ff;
      exon_sq_in    = exon_sq_ff;
      exon_cnt_in   = exon_cnt_ff;
      intron_sum_in = intron_sum_ff;
      intron_cnt_in = intron_cnt_ff;
      dropped_in    = dropped_ff;
      if (cmd.clear) begin
         exon_sum_in   = '0;
         exon_sq_in    = '0;
         exon_cnt_in   = '0;
         intron_sum_in = '0;
         intron_cnt_in = '0;
         dropped_in    = 1'b0;
      end else if (cmd.accum) begin
         if (is_intron) begin
            if (intron_full) begin
               dropped_in = 1'b1;
            end else begin
               intron_sum_in = intron_sum_ff + SUM_W'(sample);
               intron_cnt_in = intron_cnt_ff + 1'b1;
            end
         end else begin
            if (exon_full) begin
               dropped_in = 1'b1;
            end else begin
               exon_sum_in = exon_sum_ff + SUM_W'(sample);
               exon_sq_in  = exon_sq_ff + SQ_W'(sample_sq);
               exon_cnt_in = exon_cnt_ff + 1'b1;
            end
         end
      end
   end

   // Restoring division step
   assign trial    = {rem_ff, dq_ff[DVD_W-1]};
   assign trial_ge = trial >= {1'b0, div_ff};

   // Saturating sum of variance and intron mean
   assign mean_sel = status.no_intron ? '0 : dq_ff;
   assign total    = (DVD_W+1)'(varq_ff) + (DVD_W+1)'(mean_sel);

   // Multiply, divide and result datapath
   always_comb begin
      sum2_in     = sum2_ff;
      nn_in       = nn_ff;
      prod_in     = prod_ff;
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      dq_in       = dq_ff;
      rem_in      = rem_ff;
      div_in      = div_ff;
      varq_in     = varq_ff;
      score_in    = score_ff;
      too_few_in  = too_few_ff;
      overflow_in = overflow_ff;

      if (cmd.prep) begin
         sum2_in   = SUM2_W'(exon_sum_ff) * SUM2_W'(exon_sum_ff);
         nn_in     = DEN_W'(exon_cnt_ff) * DEN_W'(exon_cnt_ff - 1'b1);
         prod_in   = '0;
         mcand_in  = NUM_W'(exon_sq_ff);
         mplier_in = exon_cnt_ff;
      end
      if (cmd.mul_step) begin
         if (mplier_ff[0]) begin
            prod_in = prod_ff + mcand_ff;
         end
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
      end
      if (cmd.latch_var) begin
         varq_in = dq_ff;
      end
      if (cmd.load_var) begin
         dq_in  = DVD_W'(prod_ff - NUM_W'(sum2_ff)) << FRAC_BITS;
         rem_in = '0;
         div_in = nn_ff;
      end
      if (cmd.load_mean) begin
         // dividend top-aligned so the quotient lands in the low bits
         dq_in  = DVD_W'(intron_sum_ff) << (DVD_W - SUM_W);
         rem_in = '0;
         div_in = DEN_W'(intron_cnt_ff);
      end
      if (cmd.div_step) begin
         rem_in = trial_ge ? DEN_W'(trial - {1'b0, div_ff}) : DEN_W'(trial);
         dq_in  = {dq_ff[DVD_W-2:0], trial_ge};
      end
      if (cmd.load_out) begin
         too_few_in  = status.few;
         overflow_in = dropped_ff;
         if (status.few) begin
            score_in = '0;
         end else if (total > (DVD_W+1)'(SCORE_MAX)) begin
            score_in = SCORE_MAX;
         end else begin
            score_in = SCORE_W'(total);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exon_sum_ff   <= '0;
         exon_sq_ff    <= '0;
         exon_cnt_ff   <= '0;
         intron_sum_ff <= '0;
         intron_cnt_ff <= '0;
         dropped_ff    <= 1'b0;
      end else begin
         exon_sum_ff   <= exon_sum_in;
         exon_sq_ff    <= exon_sq_in;
         exon_cnt_ff   <= exon_cnt_in;
         intron_sum_ff <= intron_sum_in;
         intron_cnt_ff <= intron_cnt_in;
         dropped_ff    <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      sum2_ff     <= sum2_in;
      nn_ff       <= nn_in;
      prod_ff     <= prod_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      varq_ff     <= varq_in;
      score_ff    <= score_in;
      too_few_ff  <= too_few_in;
      overflow_ff <= overflow_in;
   end

   assign score    = score_ff;
   assign too_few  = too_few_ff;
   assign overflow = overflow_ff;

   // Class counts never pass the limit
   ast_exon_cnt_limit: assert property (@(posedge clock) disable iff (reset)
      (exon_cnt_ff <= CNT_W'(MAX_SAMPLES)) && (intron_cnt_ff <= CNT_W'(MAX_SAMPLES)))
      else $error("class count beyond limit");

   // A short set always scores zero
   ast_few_zero: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out && status.few |=> (score_ff == '0) && too_few_ff)
      else $error("short set with nonzero score");

endmodule

// ----- hdl/cvs_ctrl.sv -----
module cvs_ctrl import cvs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   input  logic           req_last,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  cvs_status_type status,
   output cvs_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_ACCUM,
      S_PREP,
      S_MUL,
      S_LOADV,
      S_DIVV,
      S_LOADM,
      S_DIVM,
      S_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_ACCUM: begin
            cmd.accum = req_valid;
            if (req_valid && req_last) begin
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            if (status.few) begin
               state_in = S_OUT;
            end else begin
               cmd.prep = 1'b1;
               step_in  = '0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul_step = 1'b1;
            if (step_ff == STEP_W'(CNT_W - 1)) begin
               state_in = S_LOADV;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_LOADV: begin
            cmd.load_var = 1'b1;
            step_in      = '0;
            state_in     = S_DIVV;
         end
         S_DIVV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(DVD_W - 1)) begin
               state_in = S_LOADM;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_LOADM: begin
            cmd.latch_var = 1'b1;
            step_in       = '0;
            if (status.no_intron) begin
               state_in = S_OUT;
            end else begin
               cmd.load_mean = 1'b1;
               state_in      = S_DIVM;
            end
         end
         S_DIVM: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(MEAN_W - 1)) begin
               state_in = S_OUT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_OUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               cmd.clear    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_ACCUM;
            end
         end
         default: begin
            state_in = S_ACCUM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACCUM;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == S_ACCUM;
   assign rsp_valid = rsp_valid_ff;

   // The closing word stops intake until the set is scored
   ast_last_holds: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last |=> !req_ready)
      else $error("intake open after closing word");

   // A result appears only out of the output state
   ast_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output state");

   // Step counter stays within the longest loop
   ast_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff < STEP_W'(DVD_W))
      else $error("step counter out of range");

endmodule

// ----- hdl/coverage_variance_scorer_core.sv -----
// Channel   Dir   Handshake      Word
// req_port  in    valid/ready    sample[15:0], is_intron, last
// rsp_port  out   valid/ready    score[51:0], too_few, overflow
//
// Samples are taken one per cycle while no set is being scored.
// After the closing word the set is scored by a shift-add loop for
// n*sumsq and one restoring divider shared by the variance and the
// intron mean, one bit a cycle. Without intron samples the mean pass is
// skipped; with fewer than two exon samples the multiply and both divide
// passes are skipped.
// Synchronous active-high reset clears all accumulators and control state.
// A waiting result does not block intake of the next set's samples.
module coverage_variance_scorer_core import cvs_pkg::*; (
   input logic        clock,
   input logic        reset,
   cvs_req_if.sink    req_port,
   cvs_rsp_if.source  rsp_port
);

   cvs_cmd_type    cmd;
   cvs_status_type status;

   cvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_last  (req_port.last),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cvs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sample    (req_port.sample),
      .is_intron (req_port.is_intron),
      .status    (status),
      .score     (rsp_port.score),
      .too_few   (rsp_port.too_few),
      .overflow  (rsp_port.overflow)
   );

endmodule
